// ----- design/occ_pkg.sv -----
// ---------------------------------------------------------------------------
// occ_pkg
// Shared types and constants of the occupancy grid block.
// ---------------------------------------------------------------------------
package occ_pkg;

   localparam int GRID = 128;
   localparam int AW   = $clog2(GRID);
   localparam int EW   = AW + 1;

   typedef enum logic [1:0] {
      CMD_MARK = 2'd0,
      CMD_LINE = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_EXTENT = 2'd0;
   localparam logic [1:0] CSR_RADIUS = 2'd1;
   localparam logic [1:0] CSR_CELL   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MINIT, ST_DIV, ST_BOX, ST_ROW, ST_RLOAD,
      ST_C1, ST_C2, ST_C3, ST_WROW, ST_LINIT, ST_LCHK, ST_LWAIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic            rd_en;
      logic            wr_en;
      logic [AW-1:0]   addr;
      logic [GRID-1:0] wdata;
   } ram_req_type;

   typedef struct packed {
      logic        start;
      logic [16:0] numer;
      logic [15:0] denom;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [7:0]  extent;
      logic [15:0] radius;
      logic [15:0] csize;
   } cfg_type;

endpackage

// ----- design/occ_ram.sv -----
// ---------------------------------------------------------------------------
// occ_ram
// Map storage: one word per row, one bit per cell, registered read.
// ---------------------------------------------------------------------------
module occ_ram (
   input  logic                      clock,
   input  occ_pkg::ram_req_type      req,
   output logic [occ_pkg::GRID-1:0]  rd_data
);

   logic [occ_pkg::GRID-1:0] mem [occ_pkg::GRID];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.addr];
      end
   end

endmodule

// ----- design/occ_div.sv -----
// ---------------------------------------------------------------------------
// occ_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module occ_div (
   input  logic                 clock,
   input  logic                 reset,
   input  occ_pkg::div_req_type req,
   output occ_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quot_ff, quot_in;
   logic [17:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, num_ff[16]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         num_in  = req.numer;
         den_in  = req.denom;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[15:0], 1'b0};
         if (trial >= {2'b00, den_ff}) begin
            rem_in  = 17'(trial - {2'b00, den_ff});
            quot_in = {quot_ff[15:0], 1'b1};
         end else begin
            rem_in  = trial[16:0];
            quot_in = {quot_ff[15:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ----- design/occ_seq.sv -----
// ---------------------------------------------------------------------------
// occ_seq
// Command sequencer: clearing pass, rectangle inflation, line walk, read.
// ---------------------------------------------------------------------------
module occ_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_cmd,
   input  logic signed [11:0]        req_first_x,
   input  logic signed [11:0]        req_first_y,
   input  logic signed [11:0]        req_second_x,
   input  logic signed [11:0]        req_second_y,
   output logic                      rsp_valid,
   output logic                      rsp_answer,
   input  occ_pkg::cfg_type          cfg,
   output occ_pkg::ram_req_type      ram_req,
   input  logic [occ_pkg::GRID-1:0]  rd_data,
   output occ_pkg::div_req_type      div_req,
   input  occ_pkg::div_rsp_type      div_rsp
);

   localparam int AW   = occ_pkg::AW;
   localparam int EW   = occ_pkg::EW;
   localparam int GRID = occ_pkg::GRID;

   occ_pkg::state_type state_ff, state_in;
   occ_pkg::cmd_type   cmd_ff, cmd_in;

   logic signed [11:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [11:0] ax_in, ay_in, bx_in, by_in;
   logic signed [12:0] x_ff, y_ff, x_in, y_in;
   logic signed [14:0] err_ff, err_in;
   logic [12:0]        cnt_ff, cnt_in;
   logic [11:0]        adx_ff, ady_ff, adx_in, ady_in;
   logic               sx_ff, sy_ff, sx_in, sy_in;
   logic [AW-1:0]      mx_ff, my_ff, mx_in, my_in;
   logic [AW-1:0]      bx0_ff, bx1_ff, by1_ff, bx0_in, bx1_in, by1_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [31:0]        cs2_ff, lim_ff, cs2_in, lim_in;
   logic [25:0]        dysq_ff, dxsq_ff, dysq_in, dxsq_in;
   logic [42:0]        plo_ff, phi_ff, plo_in, phi_in;
   logic [GRID-1:0]    row_ff, row_in;
   logic               ans_ff, ans_in;

   logic [EW-1:0]      ext;
   logic               in_map;
   logic               cell_bit;
   logic               last_step;
   logic signed [19:0] grow, xlo, xhi, ylo, yhi, elast;
   logic               box_empty;
   logic [26:0]        d2;
   logic [58:0]        prod;
   logic               pass;
   logic signed [12:0] ldx, ldy;

   function automatic logic [12:0] half_off(input logic [AW-1:0] c,
                                            input logic signed [11:0] lo,
                                            input logic signed [11:0] hi);
      logic signed [14:0] cc, l2, h2, cl, d;
      cc = signed'(15'({c, 1'b1}));
      l2 = 15'(signed'({lo, 1'b0}));
      h2 = 15'(signed'({hi, 1'b0}));
      cl = (cc < l2) ? l2 : ((cc > h2) ? h2 : cc);
      d  = cc - cl;
      return 13'((d < 0) ? -d : d);
   endfunction

   // shared conditions
   always_comb begin
      ext = EW'((int'(cfg.extent) > GRID) ? GRID : int'(cfg.extent));
      in_map = !x_ff[12] && !y_ff[12] &&
               (x_ff < signed'(13'(ext))) && (y_ff < signed'(13'(ext)));
      cell_bit  = rd_data[x_ff[AW-1:0]];
      last_step = (cnt_ff == 13'd0);
      grow  = signed'({3'b000, div_rsp.quot});
      elast = signed'(20'(ext)) - 20'sd1;
      xlo = 20'(ax_ff) - grow;
      ylo = 20'(ay_ff) - grow;
      xhi = 20'(bx_ff) + grow;
      yhi = 20'(by_ff) + grow;
      if (xlo < 0) xlo = '0;
      if (ylo < 0) ylo = '0;
      if (xhi > elast) xhi = elast;
      if (yhi > elast) yhi = elast;
      box_empty = (ax_ff > bx_ff) || (ay_ff > by_ff) || (xlo > xhi) || (ylo > yhi);
      d2   = 27'(dxsq_ff) + 27'(dysq_ff);
      prod = {phi_ff, 16'b0} + {16'b0, plo_ff};
      pass = prod <= {25'b0, lim_ff, 2'b00};
      ldx  = 13'(bx_ff) - 13'(ax_ff);
      ldy  = 13'(by_ff) - 13'(ay_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         occ_pkg::ST_CLEAR: if (clr_ff == AW'(GRID - 1)) state_in = occ_pkg::ST_IDLE;
         occ_pkg::ST_IDLE: begin
            if (start) begin
               unique case (occ_pkg::cmd_type'(req_cmd))
                  occ_pkg::CMD_MARK: state_in = occ_pkg::ST_MINIT;
                  occ_pkg::CMD_LINE: state_in = occ_pkg::ST_LINIT;
                  occ_pkg::CMD_READ: state_in = occ_pkg::ST_LCHK;
                  occ_pkg::CMD_NONE: state_in = occ_pkg::ST_DONE;
               endcase
            end
         end
         occ_pkg::ST_MINIT: state_in = occ_pkg::ST_DIV;
         occ_pkg::ST_DIV:   if (div_rsp.done) state_in = occ_pkg::ST_BOX;
         occ_pkg::ST_BOX:   state_in = box_empty ? occ_pkg::ST_DONE : occ_pkg::ST_ROW;
         occ_pkg::ST_ROW:   state_in = occ_pkg::ST_RLOAD;
         occ_pkg::ST_RLOAD: state_in = occ_pkg::ST_C1;
         occ_pkg::ST_C1:    state_in = occ_pkg::ST_C2;
         occ_pkg::ST_C2:    state_in = occ_pkg::ST_C3;
         occ_pkg::ST_C3:
            state_in = (mx_ff == bx1_ff) ? occ_pkg::ST_WROW : occ_pkg::ST_C1;
         occ_pkg::ST_WROW:
            state_in = (my_ff == by1_ff) ? occ_pkg::ST_DONE : occ_pkg::ST_ROW;
         occ_pkg::ST_LINIT: state_in = occ_pkg::ST_LCHK;
         occ_pkg::ST_LCHK:  state_in = in_map ? occ_pkg::ST_LWAIT : occ_pkg::ST_DONE;
         occ_pkg::ST_LWAIT: begin
            if (cmd_ff == occ_pkg::CMD_READ || cell_bit || last_step) begin
               state_in = occ_pkg::ST_DONE;
            end else begin
               state_in = occ_pkg::ST_LCHK;
            end
         end
         occ_pkg::ST_DONE:  state_in = occ_pkg::ST_IDLE;
         default:           state_in = occ_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != occ_pkg::ST_IDLE);
      rsp_valid     = (state_ff == occ_pkg::ST_DONE);
      rsp_answer    = ans_ff;
      ram_req.rd_en = 1'b0;
      ram_req.wr_en = 1'b0;
      ram_req.addr  = my_ff;
      ram_req.wdata = row_ff;
      div_req.start = (state_ff == occ_pkg::ST_MINIT);
      div_req.numer = 17'(cfg.radius) + 17'(cfg.csize) - 17'd1;
      div_req.denom = cfg.csize;
      unique case (state_ff)
         occ_pkg::ST_CLEAR: begin
            ram_req.wr_en = 1'b1;
            ram_req.addr  = clr_ff;
            ram_req.wdata = '0;
         end
         occ_pkg::ST_ROW:  ram_req.rd_en = 1'b1;
         occ_pkg::ST_WROW: ram_req.wr_en = 1'b1;
         occ_pkg::ST_LCHK: begin
            ram_req.rd_en = in_map;
            ram_req.addr  = y_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cmd_in = cmd_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  bx_in = bx_ff;  by_in = by_ff;
      x_in = x_ff;  y_in = y_ff;  err_in = err_ff;  cnt_in = cnt_ff;
      adx_in = adx_ff;  ady_in = ady_ff;  sx_in = sx_ff;  sy_in = sy_ff;
      mx_in = mx_ff;  my_in = my_ff;
      bx0_in = bx0_ff;  bx1_in = bx1_ff;  by1_in = by1_ff;
      clr_in = clr_ff;
      cs2_in = cs2_ff;  lim_in = lim_ff;
      dysq_in = dysq_ff;  dxsq_in = dxsq_ff;
      plo_in = plo_ff;  phi_in = phi_ff;
      row_in = row_ff;
      ans_in = ans_ff;
      unique case (state_ff)
         occ_pkg::ST_CLEAR: clr_in = clr_ff + AW'(1);
         occ_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in = occ_pkg::cmd_type'(req_cmd);
               ax_in  = req_first_x;
               ay_in  = req_first_y;
               bx_in  = req_second_x;
               by_in  = req_second_y;
               x_in   = 13'(req_first_x);
               y_in   = 13'(req_first_y);
               ans_in = 1'b0;
            end
         end
         occ_pkg::ST_MINIT: begin
            cs2_in = cfg.csize * cfg.csize;
            lim_in = cfg.radius * cfg.radius;
         end
         occ_pkg::ST_BOX: begin
            bx0_in = xlo[AW-1:0];
            bx1_in = xhi[AW-1:0];
            by1_in = yhi[AW-1:0];
            my_in  = ylo[AW-1:0];
         end
         occ_pkg::ST_ROW: begin
            dysq_in = half_off(my_ff, ay_ff, by_ff) * half_off(my_ff, ay_ff, by_ff);
            mx_in   = bx0_ff;
         end
         occ_pkg::ST_RLOAD: row_in = rd_data;
         occ_pkg::ST_C1:
            dxsq_in = half_off(mx_ff, ax_ff, bx_ff) * half_off(mx_ff, ax_ff, bx_ff);
         occ_pkg::ST_C2: begin
            plo_in = d2 * cs2_ff[15:0];
            phi_in = d2 * cs2_ff[31:16];
         end
         occ_pkg::ST_C3: begin
            if (pass) row_in[mx_ff] = 1'b1;
            if (mx_ff != bx1_ff) mx_in = mx_ff + AW'(1);
         end
         occ_pkg::ST_WROW: if (my_ff != by1_ff) my_in = my_ff + AW'(1);
         occ_pkg::ST_LINIT: begin
            adx_in = 12'((ldx < 0) ? -ldx : ldx);
            ady_in = 12'((ldy < 0) ? -ldy : ldy);
            cnt_in = 13'(adx_in) + 13'(ady_in);
            err_in = signed'(15'(adx_in)) - signed'(15'(ady_in));
            sx_in  = bx_ff > ax_ff;
            sy_in  = by_ff > ay_ff;
         end
         occ_pkg::ST_LCHK: if (!in_map) ans_in = 1'b0;
         occ_pkg::ST_LWAIT: begin
            if (cmd_ff == occ_pkg::CMD_READ) begin
               ans_in = cell_bit;
            end else if (cell_bit) begin
               ans_in = 1'b0;
            end else if (last_step) begin
               ans_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 13'd1;
               if (err_ff > 0) begin
                  x_in   = sx_ff ? x_ff + 13'sd1 : x_ff - 13'sd1;
                  err_in = err_ff - signed'({2'b00, ady_ff, 1'b0});
               end else begin
                  y_in   = sy_ff ? y_ff + 13'sd1 : y_ff - 13'sd1;
                  err_in = err_ff + signed'({2'b00, adx_ff, 1'b0});
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= occ_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cmd_ff  <= cmd_in;
      ax_ff   <= ax_in;   ay_ff <= ay_in;   bx_ff <= bx_in;   by_ff <= by_in;
      x_ff    <= x_in;    y_ff  <= y_in;    err_ff <= err_in; cnt_ff <= cnt_in;
      adx_ff  <= adx_in;  ady_ff <= ady_in; sx_ff <= sx_in;   sy_ff <= sy_in;
      mx_ff   <= mx_in;   my_ff <= my_in;
      bx0_ff  <= bx0_in;  bx1_ff <= bx1_in; by1_ff <= by1_in;
      cs2_ff  <= cs2_in;  lim_ff <= lim_in;
      dysq_ff <= dysq_in; dxsq_ff <= dxsq_in;
      plo_ff  <= plo_in;  phi_ff <= phi_in;
      row_ff  <= row_in;
      ans_ff  <= ans_in;
   end

endmodule

// ----- design/occupancy_grid_inflate_and_line_check.sv -----
// ---------------------------------------------------------------------------
// occupancy_grid_inflate_and_line_check
// Occupancy map with inflated obstacle marking, line check and cell read.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the single result strobe rsp_valid, whose rsp_answer must be taken that
// cycle. Registers are written on the csr channel (csr_ready is always high);
// the user must write them only while the block is idle; the block does not enforce it.
// Map storage is one row word per memory entry, with a registered read.
// Line check: up to 1 + |dx| + |dy| cells are visited.
// Mark: a radius division, then for each box row a row read, steps C1, C2
// and C3 for each box cell, and a row write-back.
// After reset the map is cleared one row per cycle, busy high.
// ---------------------------------------------------------------------------
module occupancy_grid_inflate_and_line_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [11:0] req_first_x,
   input  logic signed [11:0] req_first_y,
   input  logic signed [11:0] req_second_x,
   input  logic signed [11:0] req_second_y,
   output logic               rsp_valid,
   output logic               rsp_answer,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   occ_pkg::cfg_type             cfg_ff;
   occ_pkg::ram_req_type         ram_req;
   occ_pkg::div_req_type         div_req;
   occ_pkg::div_rsp_type         div_rsp;
   logic [occ_pkg::GRID-1:0]     rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.extent <= 8'd128;
         cfg_ff.radius <= 16'd256;
         cfg_ff.csize  <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            occ_pkg::CSR_EXTENT: cfg_ff.extent <= csr_data[7:0];
            occ_pkg::CSR_RADIUS: cfg_ff.radius <= csr_data;
            occ_pkg::CSR_CELL:   cfg_ff.csize  <= csr_data;
            default: ;
         endcase
      end
   end

   occ_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   occ_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   occ_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .rsp_valid    (rsp_valid),
      .rsp_answer   (rsp_answer),
      .cfg          (cfg_ff),
      .ram_req      (ram_req),
      .rd_data      (rd_data),
      .div_req      (div_req),
      .div_rsp      (div_rsp)
   );

endmodule

// ----- design/occ_chk.sv -----
// ---------------------------------------------------------------------------
// occ_chk
// Port-level checks of the command handshake and result strobe.
// ---------------------------------------------------------------------------
module occ_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while not busy");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but busy not raised");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && csr_ready))
      else $error("block not idle after result");

endmodule

bind occupancy_grid_inflate_and_line_check occ_chk u_occ_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_ready (csr_ready)
);

// ----- test/occupancy_grid_inflate_and_line_check_tb.sv -----
// ---------------------------------------------------------------------------
// occupancy_grid_inflate_and_line_check_tb
// Self-checking bench for the occupancy grid: marks inflated rectangles,
// checks lines and reads cells, comparing every answer with a local model
// of the map under several extent, radius and cell size settings.
// ---------------------------------------------------------------------------
module occupancy_grid_inflate_and_line_check_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N = 128;
   localparam longint LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = '0;
   logic signed [11:0] req_first_x = '0, req_first_y = '0;
   logic signed [11:0] req_second_x = '0, req_second_y = '0;
   logic rsp_valid, rsp_answer;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   occupancy_grid_inflate_and_line_check u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bit grid_bits [N][N];
   int unsigned ext_reg, radius_reg, cell_reg;
   bit answers_due [$];
   int errors = 0;
   longint cycles = 0;

   typedef struct {
      logic [1:0] cmd;
      int ax, ay, bx, by;
      int want;   // -1: use model
   } row_type;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected answer %0b", $time, rsp_answer);
            errors++;
         end else begin
            if (answers_due[0] !== rsp_answer) begin
               $display("%0t: answer expected %0b actual %0b", $time,
                        answers_due[0], rsp_answer);
               errors++;
            end
            void'(answers_due.pop_front());
         end
      end
   end

   function automatic int extent_used();
      return ext_reg > N ? N : ext_reg;
   endfunction

   function automatic bit inside_map(int x, int y);
      return x >= 0 && y >= 0 && x < extent_used() && y < extent_used();
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // value as seen on a 12-bit signed port
   function automatic int wrap12(int v);
      return ((v + 2048) & 4095) - 2048;
   endfunction

   function automatic void inflate_rect(int x0, int y0, int x1, int y1);
      int e, g, bx0, bx1, by0, by1, cx, cy, dx, dy;
      longint unsigned lim, cs2, d2;
      e = extent_used();
      lim = 4 * longint'(radius_reg) * longint'(radius_reg);
      cs2 = longint'(cell_reg) * longint'(cell_reg);
      if (x0 > x1 || y0 > y1) return;
      g = (cell_reg == 0) ? 8192 : (radius_reg + cell_reg - 1) / cell_reg;
      bx0 = x0 - g < 0 ? 0 : x0 - g;
      by0 = y0 - g < 0 ? 0 : y0 - g;
      bx1 = x1 + g > e - 1 ? e - 1 : x1 + g;
      by1 = y1 + g > e - 1 ? e - 1 : y1 + g;
      for (int y = by0; y <= by1; y++) begin
         cy = 2 * y + 1;
         dy = cy - clip(cy, 2 * y0, 2 * y1);
         for (int x = bx0; x <= bx1; x++) begin
            cx = 2 * x + 1;
            dx = cx - clip(cx, 2 * x0, 2 * x1);
            d2 = longint'(dx) * dx + longint'(dy) * dy;
            if (d2 * cs2 <= lim) grid_bits[y][x] = 1'b1;
         end
      end
   endfunction

   function automatic bit path_clear(int x0, int y0, int x1, int y1);
      int dx, dy, n, sx, sy, err, x, y;
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      dy = y1 > y0 ? y1 - y0 : y0 - y1;
      n = 1 + dx + dy;
      sx = x1 > x0 ? 1 : -1;
      sy = y1 > y0 ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      for (int i = 0; i < n; i++) begin
         if (!inside_map(x, y)) return 1'b0;
         if (grid_bits[y][x]) return 1'b0;
         if (err > 0) begin
            x += sx;
            err -= 2 * dy;
         end else begin
            y += sy;
            err += 2 * dx;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit grid_answer(logic [1:0] cmd, int ax, int ay, int bx, int by);
      case (cmd)
         occ_pkg::CMD_MARK: begin
            inflate_rect(ax, ay, bx, by);
            return 1'b0;
         end
         occ_pkg::CMD_LINE: return path_clear(ax, ay, bx, by);
         occ_pkg::CMD_READ: return inside_map(ax, ay) ? grid_bits[ay][ax] : 1'b0;
         default: return 1'b0;
      endcase
   endfunction

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      while (answers_due.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         occ_pkg::CSR_EXTENT: ext_reg = val & 8'hFF;
         occ_pkg::CSR_RADIUS: radius_reg = val & 16'hFFFF;
         occ_pkg::CSR_CELL: cell_reg = val & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send(logic [1:0] cmd, int ax, int ay, int bx, int by, int want);
      bit a;
      req_cmd <= cmd;
      req_first_x <= ax[11:0];
      req_first_y <= ay[11:0];
      req_second_x <= bx[11:0];
      req_second_y <= by[11:0];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      a = grid_answer(cmd, wrap12(ax), wrap12(ay), wrap12(bx), wrap12(by));
      if (want >= 0 && a != want[0]) begin
         $display("%0t: table row expects %0d, model gives %0b", $time, want, a);
         errors++;
      end
      answers_due = {answers_due, a};
      @(negedge clock);
      start <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int rnd_coord(int e);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4095) - 2048;
         1: return -$urandom_range(1, 3);
         2: return e - 1 + $urandom_range(0, 3);
         default: return $urandom_range(0, e > 0 ? e - 1 : 0);
      endcase
   endfunction

   task automatic random_phase(int count);
      int e, ax, ay, bx, by, k;
      logic [1:0] c;
      e = extent_used();
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 19);
         c = k < 3 ? occ_pkg::CMD_MARK :
             (k < 11 ? occ_pkg::CMD_LINE :
             (k < 19 ? occ_pkg::CMD_READ : occ_pkg::CMD_NONE));
         ax = rnd_coord(e);
         ay = rnd_coord(e);
         if (c == occ_pkg::CMD_MARK) begin
            bx = ax + $urandom_range(0, 3) - ($urandom_range(0, 7) == 0 ? 5 : 0);
            by = ay + $urandom_range(0, 3);
         end else if (c == occ_pkg::CMD_LINE && $urandom_range(0, 3) != 0) begin
            bx = clip(ax + $urandom_range(0, 40) - 20, -3, e + 2);
            by = clip(ay + $urandom_range(0, 40) - 20, -3, e + 2);
         end else begin
            bx = rnd_coord(e);
            by = rnd_coord(e);
         end
         if (c == occ_pkg::CMD_LINE && (ax < -8 || ax > 200 || bx < -8 || bx > 200)) begin
            ax = clip(ax, -3, e + 2);
            bx = clip(bx, -3, e + 2);
         end
         if (c == occ_pkg::CMD_LINE && (ay < -8 || ay > 200)) ay = clip(ay, -3, e + 2);
         if (c == occ_pkg::CMD_LINE && (by < -8 || by > 200)) by = clip(by, -3, e + 2);
         if ($urandom_range(0, 5) != 0) random_gap();
         send(c, ax, ay, bx, by, -1);
      end
   endtask

   row_type dir_rows [] = '{
      '{occ_pkg::CMD_READ, 0, 0, 0, 0, 0},
      '{occ_pkg::CMD_READ, 127, 127, 0, 0, 0},
      '{occ_pkg::CMD_LINE, 0, 0, 127, 127, 1},
      '{occ_pkg::CMD_READ, -2048, 2047, 0, 0, 0},
      '{occ_pkg::CMD_READ, 128, 0, 0, 0, 0},
      '{occ_pkg::CMD_LINE, -1, 0, 5, 0, 0},
      '{occ_pkg::CMD_LINE, 0, 0, 128, 0, 0},
      '{occ_pkg::CMD_NONE, 5, 5, 10, 10, 0},
      '{occ_pkg::CMD_READ, 5, 5, 0, 0, 0},
      '{occ_pkg::CMD_MARK, 10, 10, 9, 12, 0},
      '{occ_pkg::CMD_READ, 10, 10, 0, 0, 0},
      '{occ_pkg::CMD_MARK, 20, 20, 22, 21, 0},
      '{occ_pkg::CMD_READ, 21, 20, 0, 0, 1},
      '{occ_pkg::CMD_READ, 19, 20, 0, 0, -1},
      '{occ_pkg::CMD_READ, 18, 18, 0, 0, -1},
      '{occ_pkg::CMD_LINE, 0, 20, 40, 20, 0},
      '{occ_pkg::CMD_LINE, 40, 0, 0, 40, -1},
      '{occ_pkg::CMD_MARK, 126, 126, 2047, 2047, 0},
      '{occ_pkg::CMD_READ, 127, 127, 0, 0, 1},
      '{occ_pkg::CMD_MARK, -2048, -2048, 0, 0, 0},
      '{occ_pkg::CMD_READ, 0, 0, 0, 0, 1},
      '{occ_pkg::CMD_LINE, 60, 60, 60, 60, 1},
      '{occ_pkg::CMD_MARK, 60, 60, 60, 60, 0},
      '{occ_pkg::CMD_LINE, 60, 60, 60, 60, 0}
   };

   initial begin
      ext_reg = 128;
      radius_reg = 256;
      cell_reg = 256;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (busy) @(negedge clock);
      foreach (dir_rows[i]) begin
         if ($urandom_range(0, 1)) random_gap();
         send(dir_rows[i].cmd, dir_rows[i].ax, dir_rows[i].ay,
              dir_rows[i].bx, dir_rows[i].by, dir_rows[i].want);
      end
      random_phase(60);
      drain();
      write_reg(occ_pkg::CSR_RADIUS, 0);
      write_reg(occ_pkg::CSR_CELL, 65535);
      write_reg(occ_pkg::CSR_EXTENT, 40);
      random_phase(60);
      drain();
      write_reg(occ_pkg::CSR_RADIUS, 700);
      write_reg(occ_pkg::CSR_CELL, 300);
      write_reg(occ_pkg::CSR_EXTENT, 255);
      random_phase(60);
      drain();
      write_reg(occ_pkg::CSR_EXTENT, 1);
      random_phase(30);
      drain();
      write_reg(occ_pkg::CSR_EXTENT, 0);
      random_phase(20);
      drain();
      write_reg(occ_pkg::CSR_EXTENT, 16);
      write_reg(occ_pkg::CSR_CELL, 0);
      random_phase(10);
      drain();
      write_reg(occ_pkg::CSR_EXTENT, 64);
      write_reg(occ_pkg::CSR_CELL, 1);
      write_reg(occ_pkg::CSR_RADIUS, 3);
      random_phase(60);
      drain();
      write_reg(occ_pkg::CSR_CELL, 256);
      write_reg(occ_pkg::CSR_RADIUS, 65535);
      write_reg(occ_pkg::CSR_EXTENT, 8);
      random_phase(20);
      drain();
      write_reg(occ_pkg::CSR_EXTENT, 128);
      write_reg(occ_pkg::CSR_RADIUS, 128);
      random_phase(80);
      drain();
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// ----- sim.f -----
design/occ_pkg.sv
design/occ_ram.sv
design/occ_div.sv
design/occ_seq.sv
design/occupancy_grid_inflate_and_line_check.sv
design/occ_chk.sv
test/occupancy_grid_inflate_and_line_check_tb.sv
